/* rtl/ackrb_pkg.sv */
// shared types and constants for the ack / retransmit backoff controller
package ackrb_pkg;

  typedef enum logic [1:0] {
    CMD_ACK   = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_FAIL  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_SEND_ACK   = 3'd0,
    ACT_REPEAT_LOST = 3'd1,
    ACT_REPEAT_ALL = 3'd2,
    ACT_SEND_PEND  = 3'd3,
    ACT_RESET_FLOW = 3'd4
  } action_e;

  localparam logic [7:0]  LOST_CAP   = 8'hFF;
  localparam logic [15:0] GROW_LIMIT = 16'd7072;
  localparam logic [15:0] DELAY_CAP  = 16'd10000;
  // ceil(1.4142 * 2^27): exact floor(d*14142/10000) for every d below the limit
  localparam int unsigned GROW_SHIFT = 27;
  localparam logic [27:0] GROW_MUL   = 28'd189810711;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] stage_value;
    logic [7:0]  repeat_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

/* rtl/ack_retransmit_backoff_control.sv */
// top level: input register, event logic and result queue
//
// Sender-side acknowledgement and retransmission controller for one reliable
// flow. Each input word is one event (acknowledgement, flush or fail) and
// produces zero, one or two result words; last_o marks the final word of an
// event. An accepted word is held in the input register, is decided
// there against the flow state by combinational logic, and its results
// enter a four-entry result queue whose head drives the output port.
// A new word can be accepted every cycle while the input side does not
// stall; the single output port delivers one result per cycle while the
// receiver does not stall, so a stream of events giving two results each
// is limited by the output port. The input side stalls only while the
// input register holds an event and the result queue has fewer than two
// free entries. The repeat delay grows by a factor of about 1.4142 per
// whole-queue repeat, computed with one 13 by 28 bit multiplication by a
// fixed-point constant, and the grown value is capped at 10000 ms.
module ack_retransmit_backoff_control import ackrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] stage_ack_i,
  input  logic [31:0] lost_count_i,
  input  logic [15:0] rto_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic        queue_busy_i,
  input  logic        queue_empty_i,
  input  logic        has_pending_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [63:0] stage_value_o,
  output logic [7:0]  repeat_count_o,
  output logic        last_o
);

  // input register
  logic        in_valid_q;
  logic [1:0]  cmd_q;
  logic [63:0] stage_ack_q;
  logic [31:0] lost_count_q;
  logic [15:0] rto_ms_q;
  logic [31:0] now_ms_q;
  logic        queue_busy_q;
  logic        queue_empty_q;
  logic        has_pending_q;

  logic    room;
  logic    take;
  logic    accept;
  push_t   push;
  result_t head;

  // the held event is decided as soon as the queue can absorb two words
  assign take       = in_valid_q & room;
  assign in_stall_o = in_valid_q & ~room;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q         <= cmd_i;
      stage_ack_q   <= stage_ack_i;
      lost_count_q  <= lost_count_i;
      rto_ms_q      <= rto_ms_i;
      now_ms_q      <= now_ms_i;
      queue_busy_q  <= queue_busy_i;
      queue_empty_q <= queue_empty_i;
      has_pending_q <= has_pending_i;
    end
  end

  // flow state and decision logic
  ackrb_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .cmd_i         (cmd_q),
    .stage_ack_i   (stage_ack_q),
    .lost_count_i  (lost_count_q),
    .rto_ms_i      (rto_ms_q),
    .now_ms_i      (now_ms_q),
    .queue_busy_i  (queue_busy_q),
    .queue_empty_i (queue_empty_q),
    .has_pending_i (has_pending_q),
    .push_o        (push)
  );

  // result words wait here until the receiver takes them
  ackrb_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign action_o       = head.action;
  assign stage_value_o  = head.stage_value;
  assign repeat_count_o = head.repeat_count;
  assign last_o         = head.last;

endmodule

/* rtl/ackrb_core.sv */
// flow state registers and the combinational event decision logic
module ackrb_core import ackrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] stage_ack_i,
  input  logic [31:0] lost_count_i,
  input  logic [15:0] rto_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic        queue_busy_i,
  input  logic        queue_empty_i,
  input  logic        has_pending_i,
  output push_t       push_o
);

  logic [63:0] acked_stage_q, acked_stage_d;
  logic [31:0] lost_seen_q, lost_seen_d;
  logic [15:0] repeat_delay_q, repeat_delay_d;
  logic [31:0] repeat_stamp_q, repeat_stamp_d;

  logic [40:0] grow_prod;
  logic [15:0] grown_delay;
  logic [31:0] elapsed;
  logic [15:0] delay_mid;
  logic [7:0]  lost_sat;
  result_t     r0, r1;
  logic        v0, v1;

  assign grow_prod   = {28'd0, repeat_delay_q[12:0]} * {13'd0, GROW_MUL};
  assign grown_delay = (repeat_delay_q < GROW_LIMIT) ?
                       {2'b00, grow_prod[GROW_SHIFT +: 14]} : DELAY_CAP;
  assign elapsed     = now_ms_i - repeat_stamp_q;
  assign lost_sat    = (lost_count_i > {24'd0, LOST_CAP}) ? LOST_CAP : lost_count_i[7:0];

  always_comb begin
    acked_stage_d  = acked_stage_q;
    lost_seen_d    = lost_seen_q;
    repeat_delay_d = repeat_delay_q;
    repeat_stamp_d = repeat_stamp_q;
    delay_mid      = repeat_delay_q;
    r0 = '0;
    r1 = '0;
    v0 = 1'b0;
    v1 = 1'b0;
    unique case (cmd_i)
      CMD_ACK: begin
        if (stage_ack_i > acked_stage_q) begin
          acked_stage_d  = stage_ack_i;
          lost_seen_d    = '0;
          repeat_delay_d = rto_ms_i;
          repeat_stamp_d = now_ms_i;
          v0             = 1'b1;
          r0.action      = ACT_SEND_ACK;
          r0.stage_value = stage_ack_i;
        end else if (lost_count_i != '0 && lost_count_i > lost_seen_q) begin
          lost_seen_d     = lost_count_i;
          v0              = 1'b1;
          r0.action       = ACT_REPEAT_LOST;
          r0.repeat_count = lost_sat;
        end
      end
      CMD_FLUSH: begin
        // repeat part, then the pending send sees the updated delay
        if (!queue_busy_i) begin
          if (queue_empty_i) begin
            delay_mid = '0;
          end else if (elapsed > {16'd0, repeat_delay_q}) begin
            repeat_stamp_d = now_ms_i;
            delay_mid      = grown_delay;
            v0             = 1'b1;
            r0.action      = ACT_REPEAT_ALL;
          end
        end
        repeat_delay_d = delay_mid;
        if (has_pending_i) begin
          if (delay_mid == '0) begin
            repeat_delay_d = rto_ms_i;
            repeat_stamp_d = now_ms_i;
          end
          if (v0) begin
            v1        = 1'b1;
            r1.action = ACT_SEND_PEND;
          end else begin
            v0        = 1'b1;
            r0.action = ACT_SEND_PEND;
          end
        end
      end
      CMD_FAIL: begin
        acked_stage_d  = '0;
        lost_seen_d    = '0;
        repeat_delay_d = '0;
        v0             = 1'b1;
        r0.action      = ACT_RESET_FLOW;
      end
      default: begin
      end
    endcase
    r0.last = v0 & ~v1;
    r1.last = v1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_stage_q  <= '0;
      lost_seen_q    <= '0;
      repeat_delay_q <= '0;
      repeat_stamp_q <= '0;
    end else if (take_i) begin
      acked_stage_q  <= acked_stage_d;
      lost_seen_q    <= lost_seen_d;
      repeat_delay_q <= repeat_delay_d;
      repeat_stamp_q <= repeat_stamp_d;
    end
  end

  always_comb begin
    push_o.v0 = take_i & v0;
    push_o.v1 = take_i & v1;
    push_o.r0 = r0;
    push_o.r1 = r1;
  end

endmodule

/* rtl/ackrb_resq.sv */
// small result queue taking up to two words per cycle and giving one while the receiver does not stall
module ackrb_resq import ackrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     head_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  result_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PW:0]    count_q, count_d;
  logic           pop;
  logic [PW:0]    push_n;
  logic [PW-1:0]  wr_ptr_1;

  assign room_o      = count_q <= (PW+1)'(QUEUE_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign push_n      = (PW+1)'(push_i.v0) + (PW+1)'(push_i.v1);
  assign wr_ptr_1    = wr_ptr_q + PW'(1);
  assign count_d     = count_q + push_n - (PW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[PW-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

/* dv/ack_retransmit_backoff_control_checker.sv */
`timescale 1ns / 1ps
// flow-state predictor and result word checker for the ack / retransmit backoff controller
module ack_retransmit_backoff_control_checker import ackrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ev_valid_i,
  input  logic        ev_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] stage_ack_i,
  input  logic [31:0] lost_count_i,
  input  logic [15:0] rto_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic        queue_busy_i,
  input  logic        queue_empty_i,
  input  logic        has_pending_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [2:0]  action_i,
  input  logic [63:0] stage_value_i,
  input  logic [7:0]  repeat_count_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam logic [31:0] GROW_NUM = 32'd14142;
  localparam logic [31:0] GROW_DEN = 32'd10000;

  // predicted flow state
  logic [63:0] acked_hi;
  logic [31:0] lost_mark;
  logic [15:0] backoff_ms;
  logic [31:0] backoff_stamp;

  result_t due_results[$];

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    mismatches_o++;
  endtask

  task automatic compare_word();
    result_t want;
    if (due_results.size() == 0) begin
      note_mismatch("unexpected word, action", '0, 64'(action_i));
      return;
    end
    want = due_results.pop_front();
    if (action_i !== want.action)
      note_mismatch("action", 64'(want.action), 64'(action_i));
    if (stage_value_i !== want.stage_value)
      note_mismatch("stage_value", want.stage_value, stage_value_i);
    if (repeat_count_i !== want.repeat_count)
      note_mismatch("repeat_count", 64'(want.repeat_count), 64'(repeat_count_i));
    if (last_i !== want.last)
      note_mismatch("last", 64'(want.last), 64'(last_i));
  endtask

  // one event against the predicted state, zero to two result words
  task automatic step_flow();
    result_t     words[2];
    int          n;
    logic [31:0] elapsed;
    logic [31:0] grown;
    n        = 0;
    words[0] = '0;
    words[1] = '0;
    elapsed  = now_ms_i - backoff_stamp;
    case (cmd_i)
      CMD_ACK: begin
        if (stage_ack_i > acked_hi) begin
          acked_hi      = stage_ack_i;
          lost_mark     = '0;
          backoff_ms    = rto_ms_i;
          backoff_stamp = now_ms_i;
          words[n].action      = ACT_SEND_ACK;
          words[n].stage_value = stage_ack_i;
          n++;
        end else if (lost_count_i != '0 && lost_count_i > lost_mark) begin
          lost_mark = lost_count_i;
          words[n].action       = ACT_REPEAT_LOST;
          words[n].repeat_count = (lost_count_i > 32'(LOST_CAP)) ? LOST_CAP
                                                                 : lost_count_i[7:0];
          n++;
        end
      end
      CMD_FLUSH: begin
        if (!queue_busy_i) begin
          if (queue_empty_i) begin
            backoff_ms = '0;
          end else if (elapsed > 32'(backoff_ms)) begin
            backoff_stamp = now_ms_i;
            if (backoff_ms < GROW_LIMIT) begin
              grown      = (32'(backoff_ms) * GROW_NUM) / GROW_DEN;
              backoff_ms = grown[15:0];
            end else begin
              backoff_ms = DELAY_CAP;
            end
            words[n].action = ACT_REPEAT_ALL;
            n++;
          end
        end
        if (has_pending_i) begin
          if (backoff_ms == '0) begin
            backoff_ms    = rto_ms_i;
            backoff_stamp = now_ms_i;
          end
          words[n].action = ACT_SEND_PEND;
          n++;
        end
      end
      CMD_FAIL: begin
        acked_hi   = '0;
        lost_mark  = '0;
        backoff_ms = '0;
        words[n].action = ACT_RESET_FLOW;
        n++;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      words[k].last = (k == n - 1);
      due_results.push_back(words[k]);
    end
  endtask

  // results are compared before the new event is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_hi      = '0;
      lost_mark     = '0;
      backoff_ms    = '0;
      backoff_stamp = '0;
      due_results.delete();
    end else begin
      if (res_valid_i && !res_stall_i) compare_word();
      if (ev_valid_i && !ev_stall_i) step_flow();
    end
    outstanding_o = due_results.size();
  end

endmodule

/* dv/ack_retransmit_backoff_control_test.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the ack / retransmit backoff controller
module ack_retransmit_backoff_control_test import ackrb_pkg::*; ();

  // event code the block must ignore
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_WORDS = 1650;
  localparam int         DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;

  // event channel
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [63:0] stage_ack;
  logic [31:0] lost_count;
  logic [15:0] rto_ms;
  logic [31:0] now_ms;
  logic        queue_busy;
  logic        queue_empty;
  logic        has_pending;

  // result channel
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  action;
  logic [63:0] stage_value;
  logic [7:0]  repeat_count;
  logic        last;

  int          mismatches;
  int          outstanding;
  logic [31:0] cyc;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  ack_retransmit_backoff_control u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .stage_ack_i    (stage_ack),
    .lost_count_i   (lost_count),
    .rto_ms_i       (rto_ms),
    .now_ms_i       (now_ms),
    .queue_busy_i   (queue_busy),
    .queue_empty_i  (queue_empty),
    .has_pending_i  (has_pending),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .action_o       (action),
    .stage_value_o  (stage_value),
    .repeat_count_o (repeat_count),
    .last_o         (last)
  );

  ack_retransmit_backoff_control_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .ev_valid_i     (in_valid),
    .ev_stall_i     (in_stall),
    .cmd_i          (cmd),
    .stage_ack_i    (stage_ack),
    .lost_count_i   (lost_count),
    .rto_ms_i       (rto_ms),
    .now_ms_i       (now_ms),
    .queue_busy_i   (queue_busy),
    .queue_empty_i  (queue_empty),
    .has_pending_i  (has_pending),
    .res_valid_i    (out_valid),
    .res_stall_i    (out_stall),
    .action_i       (action),
    .stage_value_i  (stage_value),
    .repeat_count_i (repeat_count),
    .last_i         (last),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  // receiver stall pattern, switching with bits 9:8 of the cycle counter:
  // free-running, light random, on and off with bit 2 of the counter, heavy random
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      cyc       <= '0;
      out_stall <= 1'b0;
    end else begin
      cyc <= cyc + 32'd1;
      case (cyc[9:8])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 99) < 40);
        2'd2:    out_stall <= cyc[2];
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // one event word, held until the block takes it
  task automatic push_event(input logic [1:0] c, input logic [63:0] st,
                            input logic [31:0] lc, input logic [15:0] rto,
                            input logic [31:0] now, input logic busy,
                            input logic empty, input logic pend);
    @(negedge clk);
    in_valid    <= 1'b1;
    cmd         <= c;
    stage_ack   <= st;
    lost_count  <= lc;
    rto_ms      <= rto;
    now_ms      <= now;
    queue_busy  <= busy;
    queue_empty <= empty;
    has_pending <= pend;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // sender goes quiet until every predicted word has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] stage_base;
    logic [63:0] st;
    logic [31:0] lost_walk;
    logic [31:0] lc;
    logic [31:0] wall_ms;
    logic [31:0] now;
    logic [15:0] rto;
    logic [1:0]  c;
    logic        busy;
    logic        empty;
    logic        pend;
    int          burst_left;
    int          sel;
    int          sub;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    cmd         = CMD_ACK;
    stage_ack   = '0;
    lost_count  = '0;
    rto_ms      = '0;
    now_ms      = '0;
    queue_busy  = 1'b0;
    queue_empty = 1'b0;
    has_pending = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: lost count path from reset, saturation, progress
    push_event(CMD_ACK, 64'd0, 32'd0, 16'd50, 32'd10, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd0, 32'd5, 16'd50, 32'd10, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd0, 32'd3, 16'd50, 32'd10, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd0, 32'd300, 16'd50, 32'd10, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd1, 32'd0, 16'd100, 32'd1000, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd1, 32'hFFFF_FFFF, 16'd100, 32'd1000, 1'b0, 1'b0, 1'b0);
    // busy queue, elapsed equal to delay, elapsed one past delay with pending
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd100, 32'd5000, 1'b1, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd100, 32'd1100, 1'b0, 1'b0, 1'b1);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd100, 32'd1101, 1'b0, 1'b0, 1'b1);
    // empty queue clears delay, pending reloads it
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd300, 32'd1102, 1'b0, 1'b1, 1'b1);
    // largest stage and timeout, then a flush across the time wrap
    push_event(CMD_ACK, '1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'h0001_0000, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'h0001_2711, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FAIL, '1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    push_event(CMD_UNUSED, '1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
    // zero delay repeats and stays zero
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'h0001_2712, 1'b0, 1'b0, 1'b0);
    // growth just under the limit, then at the limit
    push_event(CMD_ACK, 64'd7, 32'd0, 16'd7071, 32'd200000, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'd207072, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'd217072, 1'b0, 1'b0, 1'b0);
    push_event(CMD_ACK, 64'd8, 32'd0, 16'd7072, 32'd300000, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'd307073, 1'b0, 1'b0, 1'b0);
    // busy with pending: send only
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'd307074, 1'b1, 1'b0, 1'b1);
    // after a fail, pending reloads a zero timeout
    push_event(CMD_FAIL, 64'd0, 32'd0, 16'd0, 32'd400000, 1'b0, 1'b0, 1'b0);
    push_event(CMD_FLUSH, 64'd0, 32'd0, 16'd0, 32'd400000, 1'b1, 1'b0, 1'b1);
    push_event(CMD_ACK, 64'd9, 32'd0, 16'd0, 32'd400001, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // random part: mostly well-formed ack / flush traffic on a moving clock
    stage_base = 64'd100;
    lost_walk  = '0;
    wall_ms    = 32'hFFF0_0000;
    burst_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // a stretch with no sender gaps
        if (i < 400 || i >= 650) idle_for($urandom_range(1, 8));
      end
      burst_left--;
      if (i == 1000) wait_drained();

      // time mostly creeps forward, sometimes jumps or goes anywhere
      if ($urandom_range(0, 49) == 0) wall_ms = wall_ms + $urandom;
      else wall_ms = wall_ms + $urandom_range(0, 3000);
      now = ($urandom_range(0, 29) == 0) ? $urandom : wall_ms;

      case ($urandom_range(0, 9))
        0:       rto = '0;
        1:       rto = 16'hFFFF;
        2:       rto = 16'($urandom_range(7000, 7100));
        3:       rto = 16'($urandom);
        default: rto = 16'($urandom_range(1, 2000));
      endcase

      busy  = ($urandom_range(0, 9) == 0);
      empty = ($urandom_range(0, 7) == 0);
      pend  = 1'($urandom_range(0, 1));
      st    = {$urandom, $urandom};
      lc    = $urandom;
      sel   = $urandom_range(0, 99);
      if (sel < 45) begin
        c   = CMD_ACK;
        sub = $urandom_range(0, 19);
        if (sub < 10) begin
          // progress
          stage_base = stage_base + $urandom_range(1, 50);
          st         = stage_base;
          lc         = $urandom_range(0, 10);
          lost_walk  = '0;
        end else if (sub < 16) begin
          // duplicate ack, lost count mostly climbing
          st        = stage_base - $urandom_range(0, 3);
          lost_walk = lost_walk + $urandom_range(0, 40);
          lc        = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300) : lost_walk;
        end else if (sub < 19) begin
          st = stage_base - $urandom_range(0, 3);
        end
      end else if (sel < 90) begin
        c = CMD_FLUSH;
      end else if (sel < 96) begin
        c         = CMD_FAIL;
        lost_walk = '0;
      end else begin
        c = CMD_UNUSED;
      end
      push_event(c, st, lc, rto, now, busy, empty, pend);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ackrb_pkg.sv
rtl/ackrb_core.sv
rtl/ackrb_resq.sv
rtl/ack_retransmit_backoff_control.sv
dv/ack_retransmit_backoff_control_checker.sv
dv/ack_retransmit_backoff_control_test.sv
